@@ design/wrr_pkg.sv @@
// Shared types and constants for the windowed resistance regression block.
`timescale 1ns / 1ps

package wrr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int WLEN_W   = 7;
    localparam int THR_W    = 16;
    localparam int CFG_W    = 16;
    localparam int RES_W    = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd58982;

    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_R2_THRESHOLD  = 1'b1
    } reg_index_t;

    // One sample pair plus the front-end classification.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] current_ma;
        logic signed [SAMPLE_W-1:0] voltage_mv;
        logic                       nonzero;
    } item_t;

endpackage

@@ design/wrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/wrr_front.sv @@
// Front end: accepts sample pairs, marks zero-current pairs, and queues them.
`timescale 1ns / 1ps

module wrr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [15:0] current_ma, [31:16] voltage_mv
    output logic                q_valid,
    input  logic                q_ready,
    output wrr_pkg::item_t      q_item
);

    wrr_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push, pop;
    wrr_pkg::item_t in_item;

    always_comb
    begin
        in_item.current_ma = s_tdata[15:0];
        in_item.voltage_mv = s_tdata[31:16];
        in_item.nonzero    = (s_tdata[15:0] != 16'd0);
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ design/wrr_back.sv @@
// Back end: window ring, running sums, fit test, slope division and result register.
`timescale 1ns / 1ps

module wrr_back #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  wrr_pkg::item_t      q_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tuser
);

    localparam int A_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int SQ_W  = 32 + CNT_W;
    localparam int V_W   = 2 * CNT_W + 34;
    localparam int M_W   = V_W;
    localparam int P_W   = 2 * M_W + 16;
    localparam int N_W   = M_W + 16;
    localparam int Q_W   = 34;
    localparam int C_W   = $clog2(N_W + 1);
    localparam int NT_W  = CNT_W + 1 + SQ_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_EV   = 11'b00000000010,
        S_INS  = 11'b00000000100,
        S_CHK  = 11'b00000001000,
        S_VAR  = 11'b00000010000,
        S_MULC = 11'b00000100000,
        S_MULV = 11'b00001000000,
        S_MULT = 11'b00010000000,
        S_CMP  = 11'b00100000000,
        S_DIV  = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [wrr_pkg::WLEN_W-1:0] wlen_reg, wlen_next;
    logic [wrr_pkg::THR_W-1:0]  thr_reg, thr_next;

    logic signed [15:0] cur_reg, cur_next, volt_reg, volt_next;
    logic [A_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [SUM_W-1:0] sum_i_reg, sum_i_next, sum_v_reg, sum_v_next;
    logic signed [SQ_W-1:0]  sum_ii_reg, sum_ii_next, sum_vv_reg, sum_vv_next;
    logic signed [SQ_W-1:0]  sum_iv_reg, sum_iv_next;
    logic [2:0]         step_reg, step_next;

    logic signed [V_W-1:0] term_reg, term_next;
    logic signed [V_W-1:0] vi_reg, vi_next, vv_reg, vv_next, c_reg, c_next;
    logic [P_W-1:0]     acc_reg, acc_next, a_reg, a_next, lhs_reg, lhs_next;
    logic [M_W-1:0]     b_reg, b_next;
    logic [C_W-1:0]     cnt_reg, cnt_next;
    logic [M_W-1:0]     rem_reg, rem_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic               ok_reg, ok_next;

    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_flag_reg, out_flag_next;

    // Ring access
    logic               ram_wr_en, ram_rd_en;
    logic [A_W-1:0]     slot;
    logic [31:0]        ram_rd_data;
    logic [CNT_W:0]     slot_sum;
    logic [CNT_W-1:0]   len_eff;
    logic signed [15:0] old_i, old_v;

    // Arithmetic helpers
    logic signed [15:0] pa, pb;
    logic signed [31:0] pprod;
    logic signed [SQ_W-1:0] pprod_ext;
    logic signed [SQ_W-1:0]  sel_sq;
    logic signed [SUM_W-1:0] sel_a, sel_b;
    logic signed [NT_W-1:0]  nterm;
    logic signed [2*SUM_W-1:0] sprod;
    logic signed [V_W-1:0]   var_val;
    logic               c_neg;
    logic [M_W-1:0]     c_mag;
    logic [P_W-1:0]     acc_add;
    logic [M_W:0]       div_r2;
    logic [M_W:0]       vi_ext;
    logic               div_bit;
    logic [31:0]        res_val;

    assign old_i = ram_rd_data[15:0];
    assign old_v = ram_rd_data[31:16];

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_DEPTH))
        begin
            len_eff = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_eff = CNT_W'(wlen_reg);
        end
    end

    always_comb
    begin
        slot_sum = (CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(count_reg);
        if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH))
        begin
            slot = A_W'(slot_sum - (CNT_W + 1)'(WINDOW_DEPTH));
        end
        else
        begin
            slot = A_W'(slot_sum);
        end
    end

    wrr_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot),
        .wr_data ({volt_reg, cur_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Sample products for eviction and insertion: i*i, i*v, v*v by step
    always_comb
    begin
        logic signed [15:0] si, sv;
        si = state_reg == S_EV ? old_i : cur_reg;
        sv = state_reg == S_EV ? old_v : volt_reg;
        unique case (step_reg[1:0])
            2'd0:    begin pa = si; pb = si; end
            2'd1:    begin pa = si; pb = sv; end
            default: begin pa = sv; pb = sv; end
        endcase
        pprod     = pa * pb;
        pprod_ext = SQ_W'(pprod);
    end

    // Variance terms: even step forms n*sum, odd step subtracts sum product
    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:    begin sel_sq = sum_ii_reg; sel_a = sum_i_reg; sel_b = sum_i_reg; end
            2'd1:    begin sel_sq = sum_vv_reg; sel_a = sum_v_reg; sel_b = sum_v_reg; end
            default: begin sel_sq = sum_iv_reg; sel_a = sum_i_reg; sel_b = sum_v_reg; end
        endcase
        nterm   = $signed({1'b0, count_reg}) * sel_sq;
        sprod   = sel_a * sel_b;
        var_val = term_reg - V_W'(sprod);
    end

    always_comb
    begin
        c_neg   = c_reg[V_W-1];
        c_mag   = c_neg ? M_W'(-c_reg) : M_W'(c_reg);
        acc_add = b_reg[0] ? acc_reg + a_reg : acc_reg;
        div_bit = a_reg[N_W-1];
        div_r2  = {rem_reg, div_bit};
        vi_ext  = (M_W + 1)'(vi_reg);
    end

    always_comb
    begin
        if (!c_neg)
        begin
            res_val = (ovf_reg || q_reg > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
        else
        begin
            res_val = (ovf_reg || q_reg > Q_W'(32'h8000_0000)) ? 32'h8000_0000
                                                               : (32'd0 - q_reg[31:0]);
        end
    end

    assign cfg_ready = 1'b1;
    assign q_ready   = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_flag_reg;

    always_comb
    begin
        state_next  = state_reg;
        wlen_next   = wlen_reg;
        thr_next    = thr_reg;
        cur_next    = cur_reg;
        volt_next   = volt_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        sum_i_next  = sum_i_reg;
        sum_v_next  = sum_v_reg;
        sum_ii_next = sum_ii_reg;
        sum_vv_next = sum_vv_reg;
        sum_iv_next = sum_iv_reg;
        step_next   = step_reg;
        term_next   = term_reg;
        vi_next     = vi_reg;
        vv_next     = vv_reg;
        c_next      = c_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        lhs_next    = lhs_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        ovf_next    = ovf_reg;
        ok_next     = ok_reg;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (wrr_pkg::reg_index_t'(cfg_index))
                wrr_pkg::REG_WINDOW_LENGTH: wlen_next = cfg_data[wrr_pkg::WLEN_W-1:0];
                wrr_pkg::REG_R2_THRESHOLD:  thr_next  = cfg_data[wrr_pkg::THR_W-1:0];
                default:                    wlen_next = wlen_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (q_valid)
                begin
                    cur_next  = q_item.current_ma;
                    volt_next = q_item.voltage_mv;
                    if (!q_item.nonzero)
                    begin
                        state_next = S_CHK;
                    end
                    else if (count_reg >= len_eff)
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = S_EV;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
            end
            S_EV:
            begin
                unique case (step_reg[1:0])
                    2'd0:    sum_ii_next = sum_ii_reg - pprod_ext;
                    2'd1:    sum_iv_next = sum_iv_reg - pprod_ext;
                    default: sum_vv_next = sum_vv_reg - pprod_ext;
                endcase
                if (step_reg == 3'd0)
                begin
                    sum_i_next = sum_i_reg - SUM_W'(old_i);
                    sum_v_next = sum_v_reg - SUM_W'(old_v);
                    ptr_next   = (ptr_reg == A_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                if (step_reg == 3'd2)
                begin
                    step_next  = '0;
                    state_next = S_INS;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_INS:
            begin
                unique case (step_reg[1:0])
                    2'd0:    sum_ii_next = sum_ii_reg + pprod_ext;
                    2'd1:    sum_iv_next = sum_iv_reg + pprod_ext;
                    default: sum_vv_next = sum_vv_reg + pprod_ext;
                endcase
                if (step_reg == 3'd0)
                begin
                    ram_wr_en  = 1'b1;
                    sum_i_next = sum_i_reg + SUM_W'(cur_reg);
                    sum_v_next = sum_v_reg + SUM_W'(volt_reg);
                    count_next = count_reg + 1'b1;
                end
                if (step_reg == 3'd2)
                begin
                    step_next  = '0;
                    state_next = S_CHK;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_CHK:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    if (!step_reg[0])
                    begin
                        term_next = V_W'(nterm);
                    end
                    else
                    begin
                        unique case (step_reg[2:1])
                            2'd0:    vi_next = var_val;
                            2'd1:    vv_next = var_val;
                            default: c_next  = var_val;
                        endcase
                    end
                    if (step_reg == 3'd5)
                    begin
                        step_next  = '0;
                        state_next = S_VAR;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            S_VAR:
            begin
                if (vi_reg <= 0 || vv_reg <= 0)
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    a_next     = P_W'(c_mag);
                    b_next     = c_mag;
                    acc_next   = '0;
                    cnt_next   = C_W'(M_W);
                    state_next = S_MULC;
                end
            end
            S_MULC, S_MULV, S_MULT:
            begin
                acc_next = acc_add;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == C_W'(1))
                begin
                    if (state_reg == S_MULC)
                    begin
                        lhs_next   = acc_add << wrr_pkg::FRAC_W;
                        a_next     = P_W'(M_W'(vi_reg));
                        b_next     = M_W'(vv_reg);
                        acc_next   = '0;
                        cnt_next   = C_W'(M_W);
                        state_next = S_MULV;
                    end
                    else if (state_reg == S_MULV)
                    begin
                        a_next     = acc_add;
                        b_next     = M_W'(thr_reg);
                        acc_next   = '0;
                        cnt_next   = C_W'(wrr_pkg::THR_W);
                        state_next = S_MULT;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                if (lhs_reg > acc_reg)
                begin
                    a_next     = P_W'(c_mag) << wrr_pkg::FRAC_W;
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = C_W'(N_W);
                    state_next = S_DIV;
                end
                else
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                a_next   = a_reg << 1;
                ovf_next = ovf_reg | q_reg[Q_W-1];
                cnt_next = cnt_reg - 1'b1;
                if (div_r2 >= vi_ext)
                begin
                    rem_next = M_W'(div_r2 - vi_ext);
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = M_W'(div_r2);
                    q_next   = {q_reg[Q_W-2:0], 1'b0};
                end
                if (cnt_reg == C_W'(1))
                begin
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = ok_reg;
                    out_data_next  = ok_reg ? res_val : 32'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        volt_reg <= volt_next;
        step_reg <= step_next;
        term_reg <= term_next;
        vi_reg   <= vi_next;
        vv_reg   <= vv_next;
        c_reg    <= c_next;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        lhs_reg  <= lhs_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        ok_reg   <= ok_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= wrr_pkg::WLEN_RESET;
            thr_reg       <= wrr_pkg::THR_RESET;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_i_reg     <= '0;
            sum_v_reg     <= '0;
            sum_ii_reg    <= '0;
            sum_vv_reg    <= '0;
            sum_iv_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            thr_reg       <= thr_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            sum_i_reg     <= sum_i_next;
            sum_v_reg     <= sum_v_next;
            sum_ii_reg    <= sum_ii_next;
            sum_vv_reg    <= sum_vv_next;
            sum_iv_reg    <= sum_iv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= WINDOW_DEPTH)
        else $error("stored count exceeds window depth");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("rejected fit carries nonzero slope");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_valid_reg) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("finished result not loaded into output register");

endmodule

@@ design/windowed_resistance_regression.sv @@
// Top level of the windowed resistance regression block.
`timescale 1ns / 1ps

// Estimates resistance as the least-squares slope of voltage over current across the most
// recent window_length sample pairs with nonzero current (window_length clamped to 1 to
// WINDOW_DEPTH), and reports it in signed Q16.16 ohms when r^2 exceeds r2_threshold. Each
// input pair gives exactly one result. Pairs are queued two deep in the front end; the back
// end handles one pair at a time. An accepted fit runs the variance terms through the
// bit-serial multiplier and then the restoring slope divider; a pair stored into a full
// window first evicts the oldest one. A fit rejected by the r^2 test stops after the
// multiplies; short windows or zero variance finish without either.
module windowed_resistance_regression #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] current_ma, [31:16] voltage_mv
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] resistance_q16
    output logic        m_tuser,    // [0] resistance_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic           q_valid;
    logic           q_ready;
    wrr_pkg::item_t q_item;

    wrr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    wrr_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
